/* rtl/core/bwff_pkg.sv */
package bwff_pkg;

  // field widths of the request and response items
  localparam int OPCODE_W    = 3;
  localparam int BIT_INDEX_W = 12;
  localparam int WIU_W       = 7;

  // reset value of the words in use register
  localparam logic [WIU_W-1:0] WIU_RST = 7'd64;

  // default geometry
  localparam int WORD_BITS_DEF  = 64;
  localparam int WORD_COUNT_DEF = 64;

  // summary bits scanned per cycle by a find
  localparam int SCAN_W = 64;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TEST       = 3'd0,
    OP_WRITE      = 3'd1,
    OP_FLIP       = 3'd2,
    OP_CLEAR_ALL  = 3'd3,
    OP_SET_ALL    = 3'd4,
    OP_FIND_SET   = 3'd5,
    OP_FIND_CLEAR = 3'd6,
    OP_NOP        = 3'd7
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FWORD,
    ST_FLAG
  } state_e;

endpackage

/* rtl/core/bwff_req_if.sv */
interface bwff_req_if;
  logic                              valid;
  logic                              ready;
  logic [bwff_pkg::OPCODE_W-1:0]     opcode;
  logic [bwff_pkg::BIT_INDEX_W-1:0]  bit_index;
  logic                              bit_value;

  modport source (
    output valid, opcode, bit_index, bit_value,
    input  ready
  );

  modport sink (
    input  valid, opcode, bit_index, bit_value,
    output ready
  );
endinterface

/* rtl/core/bwff_rsp_if.sv */
interface bwff_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              bit_out;
  logic                              found;
  logic [bwff_pkg::BIT_INDEX_W-1:0]  found_index;
  logic                              all_clear;
  logic                              all_set;
  logic                              index_error;

  modport source (
    output valid, bit_out, found, found_index, all_clear, all_set, index_error,
    input  ready
  );

  modport sink (
    input  valid, bit_out, found, found_index, all_clear, all_set, index_error,
    output ready
  );
endinterface

/* rtl/core/bitmap_with_find_first_core.sv */
// channel   | dir | handshake      | payload
// ----------+-----+----------------+--------------------------------------------------
// req_i     | in  | valid / ready  | opcode, bit_index, bit_value
// rsp_o     | out | valid / ready  | bit_out, found, found_index, all_clear, all_set,
//           |     |                | index_error
// cfg       | in  | cfg_we_i       | cfg_wdata_i (words in use)
//
// one request at a time; test, write, flip, clear all, set all and the no-op read the
// memory at accept, then pass through the modify/write step and the status step
// a find scans the summary in 64-word groups, at most ceil(WORD_COUNT / 64), then reads
// the found word and forms its index on a hit, and ends in the status step either way
// reset clears the per-word summary flops, no memory sweep; a request is taken at once
// a response that is not taken holds the block in its status step
module bitmap_with_find_first_core #(
  parameter int WORD_BITS  = bwff_pkg::WORD_BITS_DEF,
  parameter int WORD_COUNT = bwff_pkg::WORD_COUNT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bwff_pkg::WIU_W-1:0]    cfg_wdata_i,
  bwff_req_if.sink                      req_i,
  bwff_rsp_if.source                    rsp_o
);

  localparam int IDX_W  = bwff_pkg::BIT_INDEX_W;
  localparam int WIDX   = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int PW     = $clog2(WORD_BITS);
  localparam int QW     = $clog2(((2 ** IDX_W) - 1) / WORD_BITS + 1);
  localparam int WQ     = (QW > WIDX) ? QW : WIDX;
  localparam int NW0    = $clog2(WORD_COUNT + 1);
  localparam int NW     = (NW0 > bwff_pkg::WIU_W) ? NW0 : bwff_pkg::WIU_W;
  localparam int CW     = (WQ > NW) ? WQ : NW;
  localparam int SHIFT  = IDX_W + PW;
  localparam longint RECIP = ((64'd1 << SHIFT) + WORD_BITS - 1) / WORD_BITS;
  localparam int RW     = $clog2(RECIP + 1);
  localparam int PRODW  = IDX_W + RW;
  localparam int SCAN_W = bwff_pkg::SCAN_W;
  localparam int SOW    = $clog2(SCAN_W);
  localparam int GROUPS = (WORD_COUNT + SCAN_W - 1) / SCAN_W;
  localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int FIW    = WIDX + PW;

  // configuration
  logic [bwff_pkg::WIU_W-1:0] wiu_q;
  logic [NW-1:0]              n_raw;
  logic [NW-1:0]              n_act;
  logic [WORD_COUNT-1:0]      use_mask;

  // control and request registers
  bwff_pkg::state_e  state_q, state_d;
  bwff_pkg::opcode_e op_q, op_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              val_q, val_d;
  logic [WQ-1:0]     word_q, word_d;
  logic [GW-1:0]     group_q, group_d;

  // per-word summary: word nonzero, word all ones
  logic [WORD_COUNT-1:0] nz_q, nz_d;
  logic [WORD_COUNT-1:0] full_q, full_d;

  // result of the current request
  logic             bit_out_q, bit_out_d;
  logic             found_q, found_d;
  logic [IDX_W-1:0] fidx_q, fidx_d;
  logic             err_q, err_d;

  // response register
  logic             out_valid_q;
  logic             out_load;
  logic             out_bit_q, out_found_q, out_clear_q, out_set_q, out_err_q;
  logic [IDX_W-1:0] out_fidx_q;

  // word memory
  logic [WORD_BITS-1:0] mem [WORD_COUNT];
  logic [WORD_BITS-1:0] mem_rdata_q;
  logic                 mem_re, mem_we;
  logic [WIDX-1:0]      mem_raddr;
  logic [WIDX-1:0]      mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;

  // datapath
  logic [PRODW-1:0]         prod;
  logic [QW-1:0]            quot;
  logic [WIDX-1:0]          waddr;
  logic                     word_err;
  logic [IDX_W-1:0]         pos_full;
  logic [PW-1:0]            bpos;
  logic [WORD_BITS-1:0]     cur_word;
  logic [WORD_BITS-1:0]     bit_mask;
  logic [WORD_BITS-1:0]     new_word;
  logic [WORD_BITS-1:0]     word_hits;
  logic [PW-1:0]            hit_pos;
  logic [FIW-1:0]           found_sum;
  logic [WORD_COUNT-1:0]    sum_hits;
  logic [GROUPS*SCAN_W-1:0] hits_pad;
  logic [SCAN_W-1:0]        slice;
  logic [SOW-1:0]           scan_off;
  logic [GW+SOW-1:0]        scan_word;
  logic                     want_set;
  logic                     all_clear, all_set;

  // words in use, zero taken as one and saturated to the memory depth
  assign n_raw = (wiu_q == '0) ? NW'(1) : NW'(wiu_q);
  assign n_act = (n_raw > NW'(WORD_COUNT)) ? NW'(WORD_COUNT) : n_raw;

  for (genvar g = 0; g < WORD_COUNT; g++) begin : g_mask
    assign use_mask[g] = (NW'(g) < n_act);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wiu_q <= bwff_pkg::WIU_RST;
    end else if (cfg_we_i) begin
      wiu_q <= cfg_wdata_i;
    end
  end

  // word index by reciprocal multiply, exact for every 12-bit index
  assign prod = PRODW'(req_i.bit_index) * PRODW'(RECIP);
  assign quot = QW'(prod >> SHIFT);

  assign waddr    = WIDX'(word_q);
  assign word_err = (CW'(word_q) >= CW'(n_act));
  assign pos_full = idx_q - IDX_W'(word_q * WORD_BITS);
  assign bpos     = PW'(pos_full);

  // summary overrides memory contents after bulk operations
  always_comb begin
    if (full_q[waddr]) begin
      cur_word = '1;
    end else if (nz_q[waddr]) begin
      cur_word = mem_rdata_q;
    end else begin
      cur_word = '0;
    end
  end

  assign bit_mask = WORD_BITS'(1) << bpos;

  always_comb begin
    case (op_q)
      bwff_pkg::OP_WRITE: new_word = val_q ? (cur_word | bit_mask) : (cur_word & ~bit_mask);
      bwff_pkg::OP_FLIP:  new_word = cur_word ^ bit_mask;
      default:            new_word = cur_word;
    endcase
  end

  assign want_set  = (op_q == bwff_pkg::OP_FIND_SET);
  assign word_hits = want_set ? cur_word : ~cur_word;

  always_comb begin
    hit_pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (word_hits[i]) hit_pos = PW'(i);
    end
  end

  assign found_sum = FIW'(waddr) * FIW'(WORD_BITS) + FIW'(hit_pos);

  // summary scan, one group of words per cycle
  assign sum_hits = (want_set ? nz_q : ~full_q) & use_mask;

  always_comb begin
    hits_pad = '0;
    hits_pad[WORD_COUNT-1:0] = sum_hits;
  end

  assign slice = hits_pad[group_q*SCAN_W +: SCAN_W];

  always_comb begin
    scan_off = '0;
    for (int i = SCAN_W - 1; i >= 0; i--) begin
      if (slice[i]) scan_off = SOW'(i);
    end
  end

  assign scan_word = {group_q, scan_off};

  assign all_clear = ~|(nz_q & use_mask);
  assign all_set   = &(full_q | ~use_mask);

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    idx_d     = idx_q;
    val_d     = val_q;
    word_d    = word_q;
    group_d   = group_q;
    nz_d      = nz_q;
    full_d    = full_q;
    bit_out_d = bit_out_q;
    found_d   = found_q;
    fidx_d    = fidx_q;
    err_d     = err_q;
    mem_re    = 1'b0;
    mem_raddr = WIDX'(quot);
    mem_we    = 1'b0;
    mem_waddr = waddr;
    mem_wdata = new_word;
    out_load  = 1'b0;
    req_i.ready = 1'b0;

    unique case (state_q)
      bwff_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          op_d      = bwff_pkg::opcode_e'(req_i.opcode);
          idx_d     = req_i.bit_index;
          val_d     = req_i.bit_value;
          word_d    = WQ'(quot);
          group_d   = '0;
          bit_out_d = 1'b0;
          found_d   = 1'b0;
          fidx_d    = '0;
          err_d     = 1'b0;
          mem_re    = 1'b1;
          if (op_d == bwff_pkg::OP_FIND_SET || op_d == bwff_pkg::OP_FIND_CLEAR) begin
            state_d = bwff_pkg::ST_SCAN;
          end else begin
            state_d = bwff_pkg::ST_EXEC;
          end
        end
      end

      bwff_pkg::ST_EXEC: begin
        unique case (op_q) inside
          bwff_pkg::OP_TEST, bwff_pkg::OP_WRITE, bwff_pkg::OP_FLIP: begin
            if (word_err) begin
              err_d = 1'b1;
            end else begin
              bit_out_d = cur_word[bpos];
              if (op_q != bwff_pkg::OP_TEST) begin
                mem_we        = 1'b1;
                nz_d[waddr]   = |new_word;
                full_d[waddr] = &new_word;
              end
            end
          end
          bwff_pkg::OP_CLEAR_ALL: begin
            nz_d   = nz_q & ~use_mask;
            full_d = full_q & ~use_mask;
          end
          bwff_pkg::OP_SET_ALL: begin
            nz_d   = nz_q | use_mask;
            full_d = full_q | use_mask;
          end
          default: ;
        endcase
        state_d = bwff_pkg::ST_FLAG;
      end

      bwff_pkg::ST_SCAN: begin
        if (|slice) begin
          word_d    = WQ'(scan_word);
          mem_re    = 1'b1;
          mem_raddr = WIDX'(scan_word);
          state_d   = bwff_pkg::ST_FWORD;
        end else if (group_q == GW'(GROUPS - 1)) begin
          state_d = bwff_pkg::ST_FLAG;
        end else begin
          group_d = group_q + 1'b1;
        end
      end

      bwff_pkg::ST_FWORD: begin
        found_d = 1'b1;
        fidx_d  = IDX_W'(found_sum);
        state_d = bwff_pkg::ST_FLAG;
      end

      bwff_pkg::ST_FLAG: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = bwff_pkg::ST_IDLE;
        end
      end

      default: state_d = bwff_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bwff_pkg::ST_IDLE;
      nz_q        <= '0;
      full_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      nz_q    <= nz_d;
      full_q  <= full_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    idx_q     <= idx_d;
    val_q     <= val_d;
    word_q    <= word_d;
    group_q   <= group_d;
    bit_out_q <= bit_out_d;
    found_q   <= found_d;
    fidx_q    <= fidx_d;
    err_q     <= err_d;
    if (out_load) begin
      out_bit_q   <= bit_out_q;
      out_found_q <= found_q;
      out_fidx_q  <= fidx_q;
      out_clear_q <= all_clear;
      out_set_q   <= all_set;
      out_err_q   <= err_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.bit_out     = out_bit_q;
  assign rsp_o.found       = out_found_q;
  assign rsp_o.found_index = out_fidx_q;
  assign rsp_o.all_clear   = out_clear_q;
  assign rsp_o.all_set     = out_set_q;
  assign rsp_o.index_error = out_err_q;

  // a full word is always a nonzero word
  a_full_implies_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_q & ~nz_q) == '0)
    else $error("full summary bit without nonzero bit");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_clear_q && out_set_q))
    else $error("all clear and all set together");

  a_found_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_found_q && out_err_q))
    else $error("find result with index error");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> state_q != bwff_pkg::ST_IDLE)
    else $error("request accepted but block stayed idle");

  a_rsp_from_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == bwff_pkg::ST_FLAG)
    else $error("response raised outside the status step");

endmodule

/* tb/tb_bitmap_with_find_first_core.sv */
module tb_bitmap_with_find_first_core;
  timeunit 1ns;
  timeprecision 1ps;

  import bwff_pkg::*;

  typedef struct {
    opcode_e          op;
    logic [11:0]      idx;
    logic             val;
  } bitmap_req_t;

  typedef struct packed {
    logic             bit_out;
    logic             found;
    logic [11:0]      found_index;
    logic             all_clear;
    logic             all_set;
    logic             index_error;
  } bitmap_result_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [WIU_W-1:0] cfg_wdata_i;

  bwff_req_if req ();
  bwff_rsp_if rsp ();

  bitmap_with_find_first_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req),
    .rsp_o       (rsp)
  );

  // shadow copy of the bitmap and the words in use register
  logic [63:0]      bitmap_q [0:63];
  logic [WIU_W-1:0] wiu_q;

  bitmap_req_t      pending_req_q [$];
  bitmap_result_t   expected_result_q [$];

  int unsigned      req_issued;
  int unsigned      req_accepted;
  int unsigned      req_gap;
  int unsigned      rsp_gap;
  int unsigned      rsp_hold;
  bit               idle_en;
  int unsigned      error_count;

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic int active_words(input logic [WIU_W-1:0] wiu);
    if (wiu == 0) begin
      return 1;
    end
    return (wiu > 64) ? 64 : int'(wiu);
  endfunction

  // updates the shadow bitmap and returns the response the block must give
  function automatic bitmap_result_t apply_bitmap_op(input opcode_e op, input logic [11:0] idx,
                                                     input logic val);
    bitmap_result_t r;
    int             n;
    int             w;
    int             p;
    int             lowest;
    logic [63:0]    hits;
    r = '0;
    n = active_words(wiu_q);
    case (op)
      OP_TEST, OP_WRITE, OP_FLIP: begin
        if (int'(idx[11:6]) >= n) begin
          r.index_error = 1'b1;
        end else begin
          r.bit_out = bitmap_q[idx[11:6]][idx[5:0]];
          if (op == OP_WRITE) begin
            bitmap_q[idx[11:6]][idx[5:0]] = val;
          end else if (op == OP_FLIP) begin
            bitmap_q[idx[11:6]][idx[5:0]] = ~r.bit_out;
          end
        end
      end
      OP_CLEAR_ALL, OP_SET_ALL: begin
        for (w = 0; w < n; w++) begin
          bitmap_q[w] = (op == OP_SET_ALL) ? '1 : '0;
        end
      end
      OP_FIND_SET, OP_FIND_CLEAR: begin
        for (w = 0; w < n && !r.found; w++) begin
          hits = (op == OP_FIND_SET) ? bitmap_q[w] : ~bitmap_q[w];
          if (hits != '0) begin
            lowest = 0;
            for (p = 63; p >= 0; p--) begin
              if (hits[p]) begin
                lowest = p;
              end
            end
            r.found       = 1'b1;
            r.found_index = 12'(w * 64 + lowest);
          end
        end
      end
      default: ;
    endcase
    r.all_clear = 1'b1;
    r.all_set   = 1'b1;
    for (w = 0; w < n; w++) begin
      if (bitmap_q[w] != '0) begin
        r.all_clear = 1'b0;
      end
      if (bitmap_q[w] != '1) begin
        r.all_set = 1'b0;
      end
    end
    return r;
  endfunction

  // request side: accept at the rising edge, predict in request order
  always @(posedge clk_i) begin
    if (rst_ni && req.valid && req.ready) begin
      expected_result_q.push_back(apply_bitmap_op(opcode_e'(req.opcode), req.bit_index,
                                                  req.bit_value));
      req_accepted++;
    end
  end

  always @(negedge clk_i) begin
    bitmap_req_t item;
    if (rst_ni && req_issued == req_accepted) begin
      if (req_gap > 0) begin
        req.valid <= 1'b0;
        req_gap--;
      end else if (pending_req_q.size() != 0) begin
        item = pending_req_q.pop_front();
        req.valid     <= 1'b1;
        req.opcode    <= item.op;
        req.bit_index <= item.idx;
        req.bit_value <= item.val;
        req_issued++;
        if (idle_en && $urandom_range(0, 5) == 0) begin
          req_gap = $urandom_range(1, 9);
        end
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rsp_hold > 0) begin
      rsp.ready <= 1'b0;
      rsp_hold--;
    end else if (rsp_gap > 0) begin
      rsp.ready <= 1'b0;
      rsp_gap--;
    end else begin
      rsp.ready <= 1'b1;
      if (idle_en && $urandom_range(0, 7) == 0) begin
        rsp_gap = $urandom_range(1, 9);
      end
    end
  end

  always @(posedge clk_i) begin
    bitmap_result_t exp_r;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (expected_result_q.size() == 0) begin
        $error("response with no request outstanding");
        error_count++;
      end else begin
        exp_r = expected_result_q.pop_front();
        if (rsp.bit_out !== exp_r.bit_out) begin
          $error("bit_out: expected %0d, actual %0d", exp_r.bit_out, rsp.bit_out);
          error_count++;
        end
        if (rsp.found !== exp_r.found) begin
          $error("found: expected %0d, actual %0d", exp_r.found, rsp.found);
          error_count++;
        end
        if (rsp.found_index !== exp_r.found_index) begin
          $error("found_index: expected %0d, actual %0d", exp_r.found_index,
                 rsp.found_index);
          error_count++;
        end
        if (rsp.all_clear !== exp_r.all_clear) begin
          $error("all_clear: expected %0d, actual %0d", exp_r.all_clear, rsp.all_clear);
          error_count++;
        end
        if (rsp.all_set !== exp_r.all_set) begin
          $error("all_set: expected %0d, actual %0d", exp_r.all_set, rsp.all_set);
          error_count++;
        end
        if (rsp.index_error !== exp_r.index_error) begin
          $error("index_error: expected %0d, actual %0d", exp_r.index_error,
                 rsp.index_error);
          error_count++;
        end
      end
    end
  end

  function automatic void queue_req(input opcode_e op, input logic [11:0] idx,
                                    input logic val);
    bitmap_req_t item;
    item.op  = op;
    item.idx = idx;
    item.val = val;
    pending_req_q.push_back(item);
  endfunction

  task automatic wait_drained();
    while (pending_req_q.size() != 0 || req_issued != req_accepted ||
           expected_result_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_words_in_use(input logic [WIU_W-1:0] wiu);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= wiu;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    wiu_q = wiu;
  endtask

  // mostly in-range single-bit traffic with bulk ops mixed in, so that finds
  // see both sparse and dense maps and the all set flag gets reached
  task automatic run_random_phase(input logic [WIU_W-1:0] wiu, input int count);
    int          n;
    int          k;
    int unsigned pick;
    int unsigned sel;
    opcode_e     op;
    logic [11:0] idx;
    wait_drained();
    write_words_in_use(wiu);
    n = active_words(wiu);
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 18) begin
        op = OP_TEST;
      end else if (pick < 40) begin
        op = OP_WRITE;
      end else if (pick < 58) begin
        op = OP_FLIP;
      end else if (pick < 63) begin
        op = OP_CLEAR_ALL;
      end else if (pick < 68) begin
        op = OP_SET_ALL;
      end else if (pick < 81) begin
        op = OP_FIND_SET;
      end else if (pick < 94) begin
        op = OP_FIND_CLEAR;
      end else begin
        op = OP_NOP;
      end
      sel = $urandom_range(0, 19);
      if (sel < 16) begin
        idx = {6'($urandom_range(0, n - 1)), 6'($urandom_range(0, 63))};
      end else if (sel < 19) begin
        idx = 12'($urandom_range(0, 4095));
      end else begin
        case ($urandom_range(0, 2))
          0:       idx = '0;
          1:       idx = '1;
          default: idx = 12'(n * 64);
        endcase
      end
      queue_req(op, idx, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    req.valid     = 1'b0;
    req.opcode    = OP_NOP;
    req.bit_index = '0;
    req.bit_value = 1'b0;
    rsp.ready     = 1'b0;
    req_issued    = 0;
    req_accepted  = 0;
    req_gap       = 0;
    rsp_gap       = 0;
    rsp_hold      = 0;
    idle_en       = 1'b1;
    error_count   = 0;
    wiu_q         = WIU_RST;
    for (int w = 0; w < 64; w++) begin
      bitmap_q[w] = '0;
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: full map
    write_words_in_use(7'd64);
    queue_req(OP_TEST, 12'd0, 1'b1);
    queue_req(OP_FIND_SET, 12'd0, 1'b0);
    queue_req(OP_FIND_CLEAR, 12'd0, 1'b0);
    queue_req(OP_WRITE, 12'd4095, 1'b1);
    queue_req(OP_TEST, 12'd4095, 1'b0);
    queue_req(OP_FIND_SET, 12'd0, 1'b0);
    queue_req(OP_FLIP, 12'd0, 1'b0);
    queue_req(OP_FIND_SET, 12'd4095, 1'b1);
    queue_req(OP_SET_ALL, 12'd0, 1'b0);
    queue_req(OP_FIND_CLEAR, 12'd0, 1'b0);
    // find clear in a word other than the first must include the word offset
    queue_req(OP_WRITE, 12'd327, 1'b0);
    queue_req(OP_FIND_CLEAR, 12'd0, 1'b0);
    queue_req(OP_FLIP, 12'd327, 1'b0);
    queue_req(OP_WRITE, 12'd4095, 1'b0);
    queue_req(OP_FIND_CLEAR, 12'd0, 1'b0);
    queue_req(OP_NOP, 12'd4095, 1'b1);
    queue_req(OP_CLEAR_ALL, 12'd4095, 1'b1);
    queue_req(OP_WRITE, 12'd1365, 1'b1);
    queue_req(OP_WRITE, 12'd2730, 1'b1);
    wait_drained();

    // directed: one word only, the upper words must survive untouched
    write_words_in_use(7'd1);
    queue_req(OP_TEST, 12'd64, 1'b0);
    queue_req(OP_WRITE, 12'd4095, 1'b1);
    queue_req(OP_FLIP, 12'd63, 1'b0);
    queue_req(OP_SET_ALL, 12'd0, 1'b0);
    queue_req(OP_FIND_CLEAR, 12'd0, 1'b0);
    wait_drained();
    write_words_in_use(7'd64);
    queue_req(OP_FIND_CLEAR, 12'd0, 1'b0);
    queue_req(OP_TEST, 12'd2730, 1'b0);

    run_random_phase(7'd2, 140);
    // receiver stalls long while the sender keeps offering
    run_random_phase(7'd127, 140);
    rsp_hold = 200;
    run_random_phase(7'd0, 140);
    run_random_phase(7'd3, 140);
    run_random_phase(7'd64, 140);
    run_random_phase(7'($urandom_range(5, 63)), 140);
    run_random_phase(7'd65, 140);
    run_random_phase(7'd4, 140);
    run_random_phase(7'd1, 140);
    wait_drained();
    // no idling at all in the final stretch
    idle_en = 1'b0;
    req_gap = 0;
    rsp_gap = 0;
    run_random_phase(7'd64, 140);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("** bitmap_with_find_first_core: PASSED **");
    end else begin
      $display("** bitmap_with_find_first_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("** bitmap_with_find_first_core: FAILED **");
    $finish;
  end

endmodule
